/* rtl/nor_flash_program_erase_array_assert.svh */
// Assertion macros shared by the flash array RTL.
`ifndef NOR_FLASH_PROGRAM_ERASE_ARRAY_ASSERT_SVH
`define NOR_FLASH_PROGRAM_ERASE_ARRAY_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk and disabled during reset.
`define NFPEA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nfpea: same-cycle assertion failed");
// Next-cycle implication, clocked on clk and disabled during reset.
`define NFPEA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nfpea: next-cycle assertion failed");
`else
`define NFPEA_ASSERT_IMP(label, ante, cons)
`define NFPEA_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* rtl/nfpea_pkg.sv */
// Shared types, codes and constants of the flash array block.
package nfpea_pkg;

	// Default geometry.
	localparam int unsigned PAGE_WORDS_DEF = 256;
	localparam int unsigned PAGE_COUNT_DEF = 16;

	// Field widths.
	localparam int unsigned CMD_W    = 3;
	localparam int unsigned ADDR_W   = 14;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 16;
	// Word index taken from the byte address.
	localparam int unsigned WIDX_W   = ADDR_W - 2;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_READ    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PROGRAM = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ERASE   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_UNLOCK  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LOCK    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_MASS    = 3'd5;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_LOCKED    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERWRITE = 2'd2;

	localparam logic [DATA_W-1:0]  ERASED_WORD = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

	// Command word.
	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] write_data;
	} item_t;

	// Result word.
	typedef struct packed {
		logic [DATA_W-1:0]   read_data;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  erase_count;
	} result_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic                item_load;
		logic                mem_rd;
		logic                prog_we;
		logic                page_start;
		logic                all_start;
		logic                sweep_step;
		logic                cnt_inc;
		logic                lock_set;
		logic                lock_clr;
		logic                load_out;
		logic [STATUS_W-1:0] status;
	} ctl_t;

	// Datapath to controller status.
	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic               locked;
		logic               rd_erased;
		logic               sweep_last;
		logic               out_free;
		logic [COUNT_W-1:0] erase_count;
	} sts_t;

endpackage

/* rtl/nfpea_chan_if.sv */
// Valid/ready channel carrying one payload word.
interface nfpea_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/nfpea_ctrl.sv */
// Command sequencer of the flash array: decodes each word and drives the datapath.
module nfpea_ctrl import nfpea_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	nfpea_chan_if.sink  cmd,
	input  sts_t        sts,
	output ctl_t        ctl
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_IDX1  = 4'd2;
	localparam logic [3:0] S_IDX2  = 4'd3;
	localparam logic [3:0] S_IDX3  = 4'd4;
	localparam logic [3:0] S_IDX4  = 4'd5;
	localparam logic [3:0] S_EXEC  = 4'd6;
	localparam logic [3:0] S_CHECK = 4'd7;
	localparam logic [3:0] S_SWEEP = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0]          state_q, state_d;
	logic [STATUS_W-1:0] status_q, status_d;

	// A new word is taken only between commands.
	assign cmd.ready = (state_q == S_IDLE);

	// Next state and datapath commands.
	always_comb begin
		ctl      = '0;
		ctl.status = status_q;
		state_d  = state_q;
		status_d = status_q;
		unique case (state_q)
			S_CLEAR: begin
				ctl.sweep_step = 1'b1;
				if (sts.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (cmd.valid) begin
					ctl.item_load = 1'b1;
					state_d = S_IDX1;
				end
			end
			S_IDX1: state_d = S_IDX2;
			S_IDX2: state_d = S_IDX3;
			S_IDX3: state_d = S_IDX4;
			S_IDX4: state_d = S_EXEC;
			S_EXEC: begin
				status_d = ST_OK;
				state_d  = S_DONE;
				case (sts.command)
					CMD_READ: begin
						ctl.mem_rd = 1'b1;
						state_d = S_CHECK;
					end
					CMD_PROGRAM: begin
						if (sts.locked) begin
							status_d = ST_LOCKED;
						end else begin
							ctl.mem_rd = 1'b1;
							state_d = S_CHECK;
						end
					end
					CMD_ERASE: begin
						if (sts.locked) begin
							status_d = ST_LOCKED;
						end else begin
							ctl.page_start = 1'b1;
							ctl.cnt_inc = 1'b1;
							state_d = S_SWEEP;
						end
					end
					CMD_UNLOCK: ctl.lock_clr = 1'b1;
					CMD_LOCK:   ctl.lock_set = 1'b1;
					CMD_MASS: begin
						ctl.all_start = 1'b1;
						state_d = S_SWEEP;
					end
					default: ;
				endcase
			end
			S_CHECK: begin
				// A program may only fill a word that still reads erased.
				if (sts.command == CMD_PROGRAM) begin
					if (sts.rd_erased) ctl.prog_we = 1'b1;
					else status_d = ST_OVERWRITE;
				end
				state_d = S_DONE;
			end
			S_SWEEP: begin
				ctl.sweep_step = 1'b1;
				if (sts.sweep_last) state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					ctl.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State registers; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

endmodule

/* rtl/nfpea_dp.sv */
// Datapath of the flash array: index decode, cell memory, sweep counter, lock and output.
module nfpea_dp import nfpea_pkg::*; #(
	parameter int unsigned PAGE_WORDS = PAGE_WORDS_DEF,
	parameter int unsigned PAGE_COUNT = PAGE_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  item_t         item,
	input  ctl_t          ctl,
	output sts_t          sts,
	nfpea_chan_if.source  rsp
);

	localparam int unsigned ARRAY_WORDS = PAGE_WORDS * PAGE_COUNT;
	localparam int unsigned AW    = $clog2(ARRAY_WORDS);
	localparam int unsigned SW    = $clog2(ARRAY_WORDS + 1);
	localparam int unsigned OFF_W = $clog2(PAGE_WORDS);
	localparam int unsigned PG_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	// Reciprocal constants for exact division of a word index by the geometry.
	localparam int unsigned MUL_W  = WIDX_W + 2;
	localparam int unsigned PROD_W = WIDX_W + MUL_W;
	localparam int unsigned SH1    = WIDX_W + $clog2(PAGE_WORDS);
	localparam int unsigned SH2    = WIDX_W + $clog2(PAGE_COUNT);
	localparam logic [MUL_W-1:0] MUL1 =
		MUL_W'(((64'd1 << SH1) / 64'(PAGE_WORDS)) + 64'd1);
	localparam logic [MUL_W-1:0] MUL2 =
		MUL_W'(((64'd1 << SH2) / 64'(PAGE_COUNT)) + 64'd1);

	item_t              item_q;
	logic [WIDX_W-1:0]  widx;
	logic [PROD_W-1:0]  prod1, off_full, prod2, pg_full;
	logic [WIDX_W-1:0]  w_s1, p_s1, p_s2, q_s2;
	logic [OFF_W-1:0]   o_s2, o_s3;
	logic [PG_W-1:0]    pm_s3;
	logic [AW-1:0]      base_s4, addr_s4;
	logic [AW-1:0]      sweep_q;
	logic [SW-1:0]      left_q;
	logic [DATA_W-1:0]  cell_q [ARRAY_WORDS];
	logic [DATA_W-1:0]  rdata_q;
	logic               lock_q;
	logic [COUNT_W-1:0] count_q;
	logic               out_valid_q;
	result_t            out_q;

	// Command word held for the whole command.
	always_ff @(posedge clk) begin
		if (ctl.item_load) item_q <= item;
	end

	assign widx = item_q.address[ADDR_W-1:2];

	// Stage 1: page number of the word index.
	assign prod1 = PROD_W'(widx) * PROD_W'(MUL1);
	always_ff @(posedge clk) begin
		w_s1 <= widx;
		p_s1 <= WIDX_W'(prod1 >> SH1);
	end

	// Stage 2: offset in the page, and how often the page number wraps the array.
	assign off_full = PROD_W'(w_s1) - PROD_W'(p_s1) * PROD_W'(PAGE_WORDS);
	assign prod2    = PROD_W'(p_s1) * PROD_W'(MUL2);
	always_ff @(posedge clk) begin
		o_s2 <= OFF_W'(off_full);
		p_s2 <= p_s1;
		q_s2 <= WIDX_W'(prod2 >> SH2);
	end

	// Stage 3: page number modulo the page count.
	assign pg_full = PROD_W'(p_s2) - PROD_W'(q_s2) * PROD_W'(PAGE_COUNT);
	always_ff @(posedge clk) begin
		pm_s3 <= PG_W'(pg_full);
		o_s3  <= o_s2;
	end

	// Stage 4: page base and word address in the array.
	always_ff @(posedge clk) begin
		base_s4 <= AW'(pm_s3) * AW'(PAGE_WORDS);
		addr_s4 <= AW'(pm_s3) * AW'(PAGE_WORDS) + AW'(o_s3);
	end

	// Erase sweep: address and words left; reset arms a sweep of the whole array.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			left_q  <= SW'(ARRAY_WORDS);
		end else if (ctl.page_start) begin
			sweep_q <= base_s4;
			left_q  <= SW'(PAGE_WORDS);
		end else if (ctl.all_start) begin
			sweep_q <= '0;
			left_q  <= SW'(ARRAY_WORDS);
		end else if (ctl.sweep_step) begin
			sweep_q <= sweep_q + AW'(1);
			left_q  <= left_q - SW'(1);
		end
	end

	// Cell memory: one write port shared by sweep and program.
	always_ff @(posedge clk) begin
		if (ctl.sweep_step) cell_q[sweep_q] <= ERASED_WORD;
		else if (ctl.prog_we) cell_q[addr_s4] <= item_q.write_data;
	end

	// Cell memory read port.
	always_ff @(posedge clk) begin
		if (ctl.mem_rd) rdata_q <= cell_q[addr_s4];
	end

	// Lock flag and saturating erase counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q  <= 1'b1;
			count_q <= '0;
		end else begin
			if (ctl.lock_set) lock_q <= 1'b1;
			else if (ctl.lock_clr) lock_q <= 1'b0;
			if (ctl.cnt_inc && count_q != COUNT_MAX) count_q <= count_q + COUNT_W'(1);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (ctl.load_out) out_valid_q <= 1'b1;
		else if (rsp.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_q.read_data   <= (item_q.command == CMD_READ) ? rdata_q : '0;
			out_q.status      <= ctl.status;
			out_q.erase_count <= count_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// Status back to the sequencer.
	assign sts.command     = item_q.command;
	assign sts.locked      = lock_q;
	assign sts.rd_erased   = (rdata_q == ERASED_WORD);
	assign sts.sweep_last  = (left_q == SW'(1));
	assign sts.out_free    = !out_valid_q || rsp.ready;
	assign sts.erase_count = count_q;

endmodule

/* rtl/nor_flash_program_erase_array.sv */
// Top level of the word-addressed flash array with program and erase rules.
// The block holds PAGE_COUNT pages of PAGE_WORDS 32-bit words and takes one command word at
// a time on cmd, returning one result word on rsp. Each command passes the four-stage
// address decode and, where it needs one, the registered memory read before its result is
// loaded into the output register. A page erase clears PAGE_WORDS words and a mass erase the
// whole array through the single memory write port, which clears one word per cycle. After
// reset the same port runs a clearing pass over the whole array before the first command is
// accepted. A finished result waits in the output register while the next command runs.
`include "nor_flash_program_erase_array_assert.svh"

module nor_flash_program_erase_array import nfpea_pkg::*; #(
	parameter int unsigned PAGE_WORDS = PAGE_WORDS_DEF,
	parameter int unsigned PAGE_COUNT = PAGE_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	nfpea_chan_if.sink    cmd,
	nfpea_chan_if.source  rsp
);

	ctl_t ctl;
	sts_t sts;

	// Sequencer.
	nfpea_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.ctl    (ctl)
	);

	// Datapath.
	nfpea_dp #(
		.PAGE_WORDS (PAGE_WORDS),
		.PAGE_COUNT (PAGE_COUNT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (cmd.data),
		.ctl    (ctl),
		.sts    (sts),
		.rsp    (rsp)
	);

	// No new word is taken while a sweep is writing the array.
	`NFPEA_ASSERT_IMP(a_no_accept_in_sweep, cmd.ready, !ctl.sweep_step)
	// A result is never loaded over one that has not been taken.
	`NFPEA_ASSERT_IMP(a_load_when_free, ctl.load_out, !rsp.valid || rsp.ready)
	// A program write only lands on an erased word while unlocked.
	`NFPEA_ASSERT_IMP(a_prog_rules, ctl.prog_we, sts.rd_erased && !sts.locked)
	// The erase counter never goes down.
	`NFPEA_ASSERT_NXT(a_count_mono, 1'b1, sts.erase_count >= $past(sts.erase_count))

endmodule
